/* hw/rtl/mfa_pkg.sv */
package mfa_pkg;

  localparam int unsigned LIMBS      = 4;
  localparam int unsigned LIMB_W     = 64;
  localparam int unsigned HALF_W     = LIMB_W / 2;
  localparam int unsigned STEPS_ROW  = 2 * LIMBS + 1;
  localparam int unsigned CFG_IDX_W  = 3;

  typedef logic [LIMB_W-1:0]            limb_t;
  typedef logic [LIMBS-1:0][LIMB_W-1:0] elem_t;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_SUB  = 2'd1,
    CMD_MUL  = 2'd2,
    CMD_ZERO = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOD0 = 3'd0,
    CFG_MOD1 = 3'd1,
    CFG_MOD2 = 3'd2,
    CFG_MOD3 = 3'd3,
    CFG_MU   = 3'd4
  } cfg_idx_t;

  // Kind of word operation one cell performs.
  typedef enum logic [1:0] {
    STEP_AB = 2'd0,
    STEP_M  = 2'd1,
    STEP_MP = 2'd2
  } step_kind_t;

  // Carry folding applied to the state as it enters a cell.
  typedef enum logic [1:0] {
    FOLD_NONE    = 2'd0,
    FOLD_ROW_TOP = 2'd1,
    FOLD_ROW_END = 2'd2
  } fold_t;

  // Running CIOS state of one item.
  typedef struct packed {
    cmd_t                     cmd;
    elem_t                    a;
    elem_t                    b;
    logic [LIMBS:0][LIMB_W-1:0] t;
    logic                     t_ovf;
    limb_t                    carry;
    limb_t                    m;
  } state_t;

  // Add the product row's carry into the top word.
  function automatic state_t fold_row_top(input state_t s);
    state_t         r;
    logic [LIMB_W:0] sum;
    r        = s;
    sum      = {1'b0, s.t[LIMBS]} + {1'b0, s.carry};
    r.t[LIMBS] = sum[LIMB_W-1:0];
    r.t_ovf  = sum[LIMB_W];
    return r;
  endfunction

  // Close a reduction row: shift the top words down by one.
  function automatic state_t fold_row_end(input state_t s);
    state_t         r;
    logic [LIMB_W:0] sum;
    r            = s;
    sum          = {1'b0, s.t[LIMBS]} + {1'b0, s.carry};
    r.t[LIMBS-1] = sum[LIMB_W-1:0];
    r.t[LIMBS]   = limb_t'(s.t_ovf) + limb_t'(sum[LIMB_W]);
    r.t_ovf      = 1'b0;
    return r;
  endfunction

endpackage

/* hw/rtl/mfa_mac_cell.sv */
module mfa_mac_cell #(
  parameter mfa_pkg::step_kind_t KIND = mfa_pkg::STEP_AB,
  parameter int unsigned         ROW  = 0,
  parameter int unsigned         J    = 0,
  parameter mfa_pkg::fold_t      FOLD = mfa_pkg::FOLD_NONE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  mfa_pkg::state_t  st_in,
  input  mfa_pkg::elem_t   p,
  input  mfa_pkg::limb_t   mu,
  output logic             vld_out,
  output mfa_pkg::state_t  st_out
);
  import mfa_pkg::*;

  localparam logic [1:0] JI  = J[1:0];
  localparam logic [1:0] RI  = ROW[1:0];
  localparam logic [2:0] TJ  = 3'(J);
  localparam logic [2:0] TJ1 = (J == 0) ? 3'd0 : 3'(J - 1);

  limb_t  x, y, c, cin;
  state_t st_f;

  always_comb begin
    case (KIND)
      STEP_AB: begin
        x   = st_in.a[JI];
        y   = st_in.b[RI];
        c   = st_in.t[TJ];
        cin = (J == 0) ? '0 : st_in.carry;
      end
      STEP_M: begin
        x   = st_in.t[0];
        y   = mu;
        c   = '0;
        cin = '0;
      end
      default: begin
        x   = st_in.m;
        y   = p[JI];
        c   = st_in.t[TJ];
        cin = (J == 0) ? '0 : st_in.carry;
      end
    endcase
  end

  always_comb begin
    case (FOLD)
      FOLD_ROW_TOP: st_f = fold_row_top(st_in);
      FOLD_ROW_END: st_f = fold_row_end(st_in);
      default:      st_f = st_in;
    endcase
  end

  // Stage A: partial products
  logic                     vld_a_r;
  state_t                   st_a_r;
  logic [3:0][LIMB_W-1:0]   pp_r;
  limb_t                    c_a_r, cin_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_a_r   <= st_f;
      pp_r[0]  <= x[HALF_W-1:0]      * y[HALF_W-1:0];
      pp_r[1]  <= x[HALF_W-1:0]      * y[LIMB_W-1:HALF_W];
      pp_r[2]  <= x[LIMB_W-1:HALF_W] * y[HALF_W-1:0];
      pp_r[3]  <= x[LIMB_W-1:HALF_W] * y[LIMB_W-1:HALF_W];
      c_a_r    <= c;
      cin_a_r  <= cin;
    end
  end

  // Stage B: sum and write back
  logic [2*LIMB_W-1:0] prod;
  state_t              st_b_nxt;

  always_comb begin
    prod = (2*LIMB_W)'(pp_r[0])
         + ((2*LIMB_W)'(pp_r[1]) << HALF_W)
         + ((2*LIMB_W)'(pp_r[2]) << HALF_W)
         + ((2*LIMB_W)'(pp_r[3]) << LIMB_W)
         + (2*LIMB_W)'(c_a_r)
         + (2*LIMB_W)'(cin_a_r);
    st_b_nxt = st_a_r;
    case (KIND)
      STEP_AB: begin
        st_b_nxt.t[TJ]  = prod[LIMB_W-1:0];
        st_b_nxt.carry  = prod[2*LIMB_W-1:LIMB_W];
      end
      STEP_M: begin
        st_b_nxt.m = prod[LIMB_W-1:0];
      end
      default: begin
        if (J != 0) begin
          st_b_nxt.t[TJ1] = prod[LIMB_W-1:0];
        end
        st_b_nxt.carry = prod[2*LIMB_W-1:LIMB_W];
      end
    endcase
  end

  logic   vld_b_r;
  state_t st_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_b_r <= st_b_nxt;
    end
  end

  assign vld_out = vld_b_r;
  assign st_out  = st_b_r;

endmodule

/* hw/rtl/mfa_final.sv */
module mfa_final (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_in,
  input  mfa_pkg::state_t  st_in,
  input  mfa_pkg::elem_t   p,
  output logic             f1_vld,
  output logic             res_vld,
  output mfa_pkg::elem_t   res
);
  import mfa_pkg::*;

  // F1: raw result and its correction flag
  state_t              st_e;
  logic [4*LIMB_W:0]   addsub;
  elem_t               r_nxt;
  logic                ov_nxt;

  always_comb begin
    st_e = fold_row_end(st_in);
    case (st_in.cmd)
      CMD_ADD: addsub = {1'b0, st_in.a} + {1'b0, st_in.b};
      default: addsub = {1'b0, st_in.a} - {1'b0, st_in.b};
    endcase
    case (st_in.cmd)
      CMD_ADD: begin
        r_nxt  = addsub[4*LIMB_W-1:0];
        ov_nxt = addsub[4*LIMB_W];
      end
      CMD_SUB: begin
        r_nxt  = addsub[4*LIMB_W-1:0];
        ov_nxt = addsub[4*LIMB_W];
      end
      CMD_MUL: begin
        r_nxt  = st_e.t[LIMBS-1:0];
        ov_nxt = (st_e.t[LIMBS] != '0);
      end
      default: begin
        r_nxt  = '0;
        ov_nxt = 1'b0;
      end
    endcase
  end

  logic  f1_vld_r;
  elem_t r_r;
  logic  ov_r;
  cmd_t  cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r   <= r_nxt;
      ov_r  <= ov_nxt;
      cmd_r <= st_in.cmd;
    end
  end

  // F2: one conditional add or subtract of the modulus
  elem_t             opd;
  logic [4*LIMB_W:0] corr;
  logic              fix;
  elem_t             res_nxt;

  always_comb begin
    opd  = (cmd_r == CMD_SUB) ? p : ~p;
    corr = {1'b0, r_r} + {1'b0, opd} + ((4*LIMB_W+1)'(cmd_r != CMD_SUB));
    case (cmd_r)
      CMD_SUB: fix = ov_r;
      CMD_ADD: fix = ov_r | corr[4*LIMB_W];
      CMD_MUL: fix = ov_r | corr[4*LIMB_W];
      default: fix = 1'b0;
    endcase
    res_nxt = fix ? corr[4*LIMB_W-1:0] : r_r;
  end

  logic  res_vld_r;
  elem_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (en) begin
      res_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign f1_vld  = f1_vld_r;
  assign res_vld = res_vld_r;
  assign res     = res_r;

endmodule

/* hw/rtl/montgomery_field_alu.sv */
// Pipeline: 36 two-stage word cells, a result stage and the output register
// lie between item acceptance and out_valid.
// Throughput: one item per cycle; the whole chain advances in lockstep and
// holds only while a finished result waits under out_stall.
// Reset (rst_n low, synchronous): clears all valid bits and zeroes the
// modulus and Montgomery factor registers.
module montgomery_field_alu (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration
  input  logic                            cfg_we,
  input  logic [mfa_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [63:0]                     cfg_wdata,
  // input items
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_cmd,
  input  logic [63:0]                     in_a_limb0,
  input  logic [63:0]                     in_a_limb1,
  input  logic [63:0]                     in_a_limb2,
  input  logic [63:0]                     in_a_limb3,
  input  logic [63:0]                     in_b_limb0,
  input  logic [63:0]                     in_b_limb1,
  input  logic [63:0]                     in_b_limb2,
  input  logic [63:0]                     in_b_limb3,
  // result items
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [63:0]                     out_res_limb0,
  output logic [63:0]                     out_res_limb1,
  output logic [63:0]                     out_res_limb2,
  output logic [63:0]                     out_res_limb3
);
  import mfa_pkg::*;

  localparam int unsigned NCELLS = LIMBS * STEPS_ROW;

  // Configuration registers; written only while the block is idle (the user's duty; the block does not enforce it).
  elem_t mod_r;
  limb_t mu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= '0;
      mu_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MOD0: mod_r[0] <= cfg_wdata;
        CFG_MOD1: mod_r[1] <= cfg_wdata;
        CFG_MOD2: mod_r[2] <= cfg_wdata;
        CFG_MOD3: mod_r[3] <= cfg_wdata;
        CFG_MU:   mu_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the whole chain unless a finished item waits at the output.
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Build the entering state: zero accumulator.
  state_t st_in;
  always_comb begin
    st_in       = '0;
    st_in.cmd   = cmd_t'(in_cmd);
    st_in.a     = {in_a_limb3, in_a_limb2, in_a_limb1, in_a_limb0};
    st_in.b     = {in_b_limb3, in_b_limb2, in_b_limb1, in_b_limb0};
  end

  logic   [NCELLS:0] vld_c;
  state_t            st_c [NCELLS+1];

  assign vld_c[0] = in_valid && !in_stall;
  assign st_c[0]  = st_in;

  // Each row: four product words, the reduction factor, four reduction words.
  for (genvar r = 0; r < LIMBS; r++) begin : g_row
    for (genvar s = 0; s < STEPS_ROW; s++) begin : g_step
      localparam step_kind_t KIND = (s < LIMBS) ? STEP_AB :
                                    (s == LIMBS) ? STEP_M : STEP_MP;
      localparam int unsigned JJ  = (s < LIMBS) ? s :
                                    (s == LIMBS) ? 0 : s - LIMBS - 1;
      localparam fold_t FOLD      = (s == 0 && r > 0) ? FOLD_ROW_END :
                                    (s == LIMBS) ? FOLD_ROW_TOP : FOLD_NONE;
      localparam int unsigned IDX = r * STEPS_ROW + s;

      mfa_mac_cell #(
        .KIND (KIND),
        .ROW  (r),
        .J    (JJ),
        .FOLD (FOLD)
      ) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (vld_c[IDX]),
        .st_in   (st_c[IDX]),
        .p       (mod_r),
        .mu      (mu_r),
        .vld_out (vld_c[IDX+1]),
        .st_out  (st_c[IDX+1])
      );
    end
  end

  // Close the last row, form add/sub results, correct once, register out.
  logic  f1_vld;
  elem_t res;

  mfa_final u_final (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .vld_in  (vld_c[NCELLS]),
    .st_in   (st_c[NCELLS]),
    .p       (mod_r),
    .f1_vld  (f1_vld),
    .res_vld (out_valid),
    .res     (res)
  );

  assign out_res_limb0 = res[0];
  assign out_res_limb1 = res[1];
  assign out_res_limb2 = res[2];
  assign out_res_limb3 = res[3];

  // A finished item in the result stage reaches the output on advance.
  a_f1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && f1_vld) |=> out_valid)
    else $error("result stage item lost on advance");

  // Hold the chain while the output is stalled.
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv) |=> (f1_vld == $past(f1_vld)) && (vld_c[NCELLS] == $past(vld_c[NCELLS])))
    else $error("pipeline moved while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    (!rst_n) |=> !out_valid)
    else $error("output valid after reset");

endmodule

/* tb/sv/montgomery_field_alu_checker.sv */
module montgomery_field_alu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [mfa_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [63:0] in_a_limb0,
  input  logic [63:0] in_a_limb1,
  input  logic [63:0] in_a_limb2,
  input  logic [63:0] in_a_limb3,
  input  logic [63:0] in_b_limb0,
  input  logic [63:0] in_b_limb1,
  input  logic [63:0] in_b_limb2,
  input  logic [63:0] in_b_limb3,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [63:0] out_res_limb0,
  input  logic [63:0] out_res_limb1,
  input  logic [63:0] out_res_limb2,
  input  logic [63:0] out_res_limb3,
  output int          err_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mfa_pkg::*;

  logic [255:0] prime;
  limb_t        mu;
  logic [255:0] field_results[$];

  function automatic logic [255:0] reduce_once(logic [255:0] r, logic ovf);
    if (ovf || r >= prime) return r - prime;
    return r;
  endfunction

  function automatic logic [255:0] field_op(cmd_t op, logic [255:0] a, logic [255:0] b);
    logic [256:0] wide;
    logic [384:0] t;
    logic [127:0] prod;
    limb_t        m;
    wide = 0;
    t = 0;
    case (op)
      CMD_ADD: begin
        wide = {1'b0, a} + {1'b0, b};
        return reduce_once(wide[255:0], wide[256]);
      end
      CMD_SUB: begin
        if (a < b) return a - b + prime;
        return a - b;
      end
      CMD_MUL: begin
        // word-serial CIOS: accumulate, reduce, shift by one limb
        for (int i = 0; i < LIMBS; i++) begin
          t = t + a * b[64*i +: 64];
          prod = t[63:0] * mu;
          m = prod[63:0];
          t = (t + m * prime) >> 64;
        end
        return reduce_once(t[255:0], t[256]);
      end
      default: return '0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  initial err_count = 0;

  always @(posedge clk) begin
    logic [255:0] want;
    if (!rst_n) begin
      prime <= '0;
      mu    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MOD0: prime[63:0]    <= cfg_wdata;
          CFG_MOD1: prime[127:64]  <= cfg_wdata;
          CFG_MOD2: prime[191:128] <= cfg_wdata;
          CFG_MOD3: prime[255:192] <= cfg_wdata;
          CFG_MU:   mu             <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        field_results.push_back(field_op(cmd_t'(in_cmd),
          {in_a_limb3, in_a_limb2, in_a_limb1, in_a_limb0},
          {in_b_limb3, in_b_limb2, in_b_limb1, in_b_limb0}));
      if (out_valid && !out_stall) begin
        if (field_results.size() == 0) begin
          report_mismatch("unexpected result item", out_res_limb0, '0);
        end else begin
          want = field_results.pop_front();
          if (out_res_limb0 !== want[63:0])    report_mismatch("res_limb0", out_res_limb0, want[63:0]);
          if (out_res_limb1 !== want[127:64])  report_mismatch("res_limb1", out_res_limb1, want[127:64]);
          if (out_res_limb2 !== want[191:128]) report_mismatch("res_limb2", out_res_limb2, want[191:128]);
          if (out_res_limb3 !== want[255:192]) report_mismatch("res_limb3", out_res_limb3, want[255:192]);
        end
      end
    end
    pending = field_results.size();
  end
endmodule

/* tb/sv/montgomery_field_alu_tb.sv */
module montgomery_field_alu_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mfa_pkg::*;

  localparam int LATENCY   = 74;
  localparam int MAX_CYCLE = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [63:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic [63:0] in_a_limb0 = '0, in_a_limb1 = '0, in_a_limb2 = '0, in_a_limb3 = '0;
  logic [63:0] in_b_limb0 = '0, in_b_limb1 = '0, in_b_limb2 = '0, in_b_limb3 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_res_limb0, out_res_limb1, out_res_limb2, out_res_limb3;

  int err_count;
  int pending;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic [255:0] prime;

  // BN254 scalar field and its Montgomery factor
  localparam logic [255:0] BN_FR =
    256'h30644e72e131a029b85045b68181585d2833e84879b9709143e1f593f0000001;
  localparam limb_t BN_MU = 64'hc2e1f593efffffff;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  montgomery_field_alu dut (.*);

  montgomery_field_alu_checker checker_i (.*);

  // Count cycles; end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("montgomery_field_alu_tb: done, errors");
      $finish;
    end
  end

  // Result side: stall at random, changed at the falling edge.
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  function automatic logic [255:0] rand_wide();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // Random value, mostly below the modulus, biased toward its edges.
  function automatic logic [255:0] rand_elem();
    logic [255:0] v;
    case ($urandom_range(7))
      0: v = '0;
      1: v = prime - 1;
      2: v = prime - $urandom_range(16);
      3: v = $urandom_range(16);
      4: return rand_wide();   // occasionally unreduced
      default: v = rand_wide();
    endcase
    if (prime != 0 && v >= prime) v = v % prime;
    return v;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_field(logic [255:0] p, limb_t m);
    write_reg(CFG_MOD0, p[63:0]);
    write_reg(CFG_MOD1, p[127:64]);
    write_reg(CFG_MOD2, p[191:128]);
    write_reg(CFG_MOD3, p[255:192]);
    write_reg(CFG_MU, m);
    prime = p;
  endtask

  // Present one item and hold it until accepted.
  task automatic send_item(cmd_t op, logic [255:0] a, logic [255:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_cmd     <= op;
    {in_a_limb3, in_a_limb2, in_a_limb1, in_a_limb0} <= a;
    {in_b_limb3, in_b_limb2, in_b_limb1, in_b_limb0} <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait for the pipeline to drain before touching config.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  // Mix of mostly real field ops with some odd commands and operands.
  task automatic random_phase(int n);
    logic [255:0] a;
    for (int i = 0; i < n; i++) begin
      a = rand_elem();
      case ($urandom_range(9))
        0, 1, 2: send_item(CMD_ADD, a, rand_elem());
        3, 4, 5: send_item(CMD_SUB, a, rand_elem());
        6:       send_item(CMD_MUL, a, a);
        7:       send_item(CMD_ZERO, a, rand_wide());
        default: send_item(CMD_MUL, a, rand_elem());
      endcase
    end
  endtask

  initial begin
    logic [255:0] odd_p;
    prime = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Registers all zero after reset: add and subtract wrap modulo 2^256.
    send_item(CMD_ADD, '1, 256'd1);
    send_item(CMD_SUB, '0, 256'd1);
    send_item(CMD_MUL, '1, '1);
    send_item(CMD_ZERO, '1, '1);
    drain();

    // Directed edges over the real field.
    load_field(BN_FR, BN_MU);
    send_item(CMD_ADD, BN_FR - 1, BN_FR - 1);
    send_item(CMD_ADD, BN_FR - 1, 256'd1);
    send_item(CMD_ADD, '0, '0);
    send_item(CMD_SUB, '0, BN_FR - 1);
    send_item(CMD_SUB, BN_FR - 1, BN_FR - 1);
    send_item(CMD_SUB, 256'd1, 256'd2);
    send_item(CMD_MUL, BN_FR - 1, BN_FR - 1);
    send_item(CMD_MUL, 256'd1, 256'd1);
    send_item(CMD_MUL, '0, BN_FR - 1);
    send_item(CMD_MUL, '1, '1);
    send_item(CMD_ADD, '1, '1);
    send_item(CMD_SUB, '0, '1);
    send_item(CMD_ZERO, BN_FR - 1, '1);
    drain();

    // Random phases: none, sender idle, receiver stall, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 13 : 0;
      recv_stall_pct = (ph == 2) ? 56 : (ph == 3) ? 13 : 0;
      random_phase(200);
      drain();
    end

    // Extremes of the configuration: all-ones modulus, then a random odd
    // one with a random factor, then back to the real field.
    load_field('1, 64'd1);
    send_idle_pct = 0;
    recv_stall_pct = 30;
    random_phase(80);
    drain();
    odd_p = rand_wide() | 256'd1;
    load_field(odd_p, {$urandom, $urandom});
    random_phase(80);
    drain();
    load_field(BN_FR, BN_MU);
    send_idle_pct = 20;
    random_phase(60);
    drain();

    if (err_count == 0)
      $display("montgomery_field_alu_tb: done, clean");
    else
      $display("montgomery_field_alu_tb: done, errors");
    $finish;
  end
endmodule
